FILE: sv/multichannel_servo_pulse_generator_macros.svh
// ------------------------------------------------------------------
// Servo pulse generator assertion macros
// Concurrent check wrappers, clocked on clk_i and disabled in reset.
// ------------------------------------------------------------------
`ifndef MULTICHANNEL_SERVO_PULSE_GENERATOR_MACROS_SVH
`define MULTICHANNEL_SERVO_PULSE_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define MSPG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define MSPG_ASSERT_NEVER(name, expr, msg) \
  `MSPG_ASSERT(name, !(expr), msg)
`else
`define MSPG_ASSERT(name, prop, msg)
`define MSPG_ASSERT_NEVER(name, expr, msg)
`endif
`endif

FILE: sv/mspg_pkg.sv
// ------------------------------------------------------------------
// Servo pulse generator package
// Widths, codes, reset values and shared types.
// ------------------------------------------------------------------
package mspg_pkg;

  localparam int CHANNELS   = 32;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W       = 5;
  localparam int SLOT_W     = 19;
  localparam int BIT_IDX_W  = $clog2(SLOT_W);
  localparam int WORD_W     = 32;
  localparam int PIN_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  localparam logic [SLOT_W-1:0] RST_CYCLE_SLOTS   = SLOT_W'(2000);
  localparam logic [SLOT_W-1:0] RST_MIN_WIDTH     = SLOT_W'(50);
  localparam logic [SLOT_W-1:0] RST_MAX_WIDTH     = SLOT_W'(250);
  localparam logic [WORD_W-1:0] RST_CHAN_ENABLE   = WORD_W'(255);
  localparam logic [SLOT_W-1:0] RST_START_SPACING = SLOT_W'(250);
  localparam logic [WORD_W-1:0] RST_IDLE_TICKS    = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CYCLE_SLOTS    = 3'd0,
    REG_MIN_WIDTH      = 3'd1,
    REG_MAX_WIDTH      = 3'd2,
    REG_CHAN_ENABLE    = 3'd3,
    REG_START_SPACING  = 3'd4,
    REG_IDLE_TICKS     = 3'd5,
    REG_INVERT_OUTPUTS = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_INC  = 2'd2,
    OP_DEC  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_DISABLED = 2'd2
  } status_e;

  typedef enum logic {
    KIND_LEVELS = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // per-channel state word held in the channel RAM
  typedef struct packed {
    logic [SLOT_W-1:0] req_width;
    logic [SLOT_W-1:0] act_width;
    logic              turn_on;
    logic [WORD_W-1:0] idle_cnt;
  } chan_ent_t;

  localparam int ENT_W = $bits(chan_ent_t);

  typedef struct packed {
    logic [SLOT_W-1:0]   cyc_eff;
    logic [SLOT_W-1:0]   min_w;
    logic [SLOT_W-1:0]   max_w;
    logic [CHANNELS-1:0] enable;
    logic [SLOT_W-1:0]   sp_mod;
    logic [WORD_W-1:0]   idle_ticks;
    logic                invert;
    logic                busy;
  } cfg_t;

  typedef struct packed {
    opcode_e           op;
    logic [CH_W-1:0]   ch;
    logic [SLOT_W-1:0] amt;
  } cmd_t;

  typedef struct packed {
    kind_e            kind;
    logic [PIN_W-1:0] pins;
    status_e          status;
  } res_t;

endpackage

FILE: sv/mspg_ifs.sv
// ------------------------------------------------------------------
// Servo pulse generator channel interfaces
// Command, result and configuration write channels (valid/ready).
// ------------------------------------------------------------------
interface mspg_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [mspg_pkg::CH_W-1:0]   channel;
  logic [mspg_pkg::SLOT_W-1:0] amount;

  modport source (output valid, opcode, channel, amount, input ready);
  modport sink   (input valid, opcode, channel, amount, output ready);
endinterface

interface mspg_res_if;
  logic                       valid;
  logic                       ready;
  logic                       result_kind;
  logic [mspg_pkg::PIN_W-1:0] pin_levels;
  logic [1:0]                 status;

  modport source (output valid, result_kind, pin_levels, status, input ready);
  modport sink   (input valid, result_kind, pin_levels, status, output ready);
endinterface

interface mspg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mspg_pkg::CFG_IDX_W-1:0] index;
  logic [mspg_pkg::WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/mspg_ram.sv
// ------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered (read-first).
// ------------------------------------------------------------------
module mspg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/mspg_cfg.sv
// ------------------------------------------------------------------
// Servo pulse generator configuration registers
// Register file plus a bit-serial unit for start_spacing mod cycle.
// ------------------------------------------------------------------
`include "multichannel_servo_pulse_generator_macros.svh"

module mspg_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  mspg_cfg_if.sink        cfg_i,
  output mspg_pkg::cfg_t  cfg_o
);

  logic [mspg_pkg::SLOT_W-1:0]    cyc_q, min_q, max_q, spc_q, spmod_q, rem_q, rem_d;
  logic [mspg_pkg::CHANNELS-1:0]  en_q;
  logic [mspg_pkg::WORD_W-1:0]    idle_q;
  logic                           inv_q, busy_q;
  logic [mspg_pkg::BIT_IDX_W-1:0] bit_q;
  logic [mspg_pkg::SLOT_W-1:0]    cyc_eff;
  logic [mspg_pkg::SLOT_W:0]      rem_sh;
  logic                           wr;
  mspg_pkg::cfg_reg_e             idx;

  assign cfg_i.ready = 1'b1;
  assign wr  = cfg_i.valid && cfg_i.ready;
  assign idx = mspg_pkg::cfg_reg_e'(cfg_i.index);

  // zero cycle length behaves as one slot
  assign cyc_eff = (cyc_q == '0) ? mspg_pkg::SLOT_W'(1) : cyc_q;

  // restoring remainder, one dividend bit per cycle, MSB first
  always_comb begin
    rem_sh = {rem_q, spc_q[bit_q]};
    if (rem_sh >= {1'b0, cyc_eff}) begin
      rem_d = mspg_pkg::SLOT_W'(rem_sh - {1'b0, cyc_eff});
    end else begin
      rem_d = rem_sh[mspg_pkg::SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_q   <= mspg_pkg::RST_CYCLE_SLOTS;
      min_q   <= mspg_pkg::RST_MIN_WIDTH;
      max_q   <= mspg_pkg::RST_MAX_WIDTH;
      en_q    <= mspg_pkg::RST_CHAN_ENABLE[mspg_pkg::CHANNELS-1:0];
      spc_q   <= mspg_pkg::RST_START_SPACING;
      idle_q  <= mspg_pkg::RST_IDLE_TICKS;
      inv_q   <= 1'b0;
      busy_q  <= 1'b0;
      bit_q   <= '0;
      rem_q   <= '0;
      spmod_q <= mspg_pkg::RST_START_SPACING;
    end else begin
      if (wr) begin
        unique case (idx)
          mspg_pkg::REG_CYCLE_SLOTS:    cyc_q  <= cfg_i.data[mspg_pkg::SLOT_W-1:0];
          mspg_pkg::REG_MIN_WIDTH:      min_q  <= cfg_i.data[mspg_pkg::SLOT_W-1:0];
          mspg_pkg::REG_MAX_WIDTH:      max_q  <= cfg_i.data[mspg_pkg::SLOT_W-1:0];
          mspg_pkg::REG_CHAN_ENABLE:    en_q   <= cfg_i.data[mspg_pkg::CHANNELS-1:0];
          mspg_pkg::REG_START_SPACING:  spc_q  <= cfg_i.data[mspg_pkg::SLOT_W-1:0];
          mspg_pkg::REG_IDLE_TICKS:     idle_q <= cfg_i.data;
          mspg_pkg::REG_INVERT_OUTPUTS: inv_q  <= cfg_i.data[0];
          default: ;
        endcase
      end
      if (wr && (idx == mspg_pkg::REG_CYCLE_SLOTS || idx == mspg_pkg::REG_START_SPACING)) begin
        busy_q <= 1'b1;
        bit_q  <= mspg_pkg::BIT_IDX_W'(mspg_pkg::SLOT_W - 1);
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= rem_d;
        if (bit_q == '0) begin
          busy_q  <= 1'b0;
          spmod_q <= rem_d;
        end else begin
          bit_q <= bit_q - mspg_pkg::BIT_IDX_W'(1);
        end
      end
    end
  end

  always_comb begin
    cfg_o.cyc_eff    = cyc_eff;
    cfg_o.min_w      = min_q;
    cfg_o.max_w      = max_q;
    cfg_o.enable     = en_q;
    cfg_o.sp_mod     = spmod_q;
    cfg_o.idle_ticks = idle_q;
    cfg_o.invert     = inv_q;
    cfg_o.busy       = busy_q;
  end

  `MSPG_ASSERT(spmod_below_cycle_a, !busy_q |-> (spmod_q < cyc_eff), "spacing remainder not reduced")
  `MSPG_ASSERT(mod_bits_count_down_a, busy_q && !wr && bit_q != '0 |=> busy_q && bit_q == $past(bit_q) - mspg_pkg::BIT_IDX_W'(1), "modulo unit skipped a bit")

endmodule

FILE: sv/mspg_engine.sv
// ------------------------------------------------------------------
// Servo pulse generator channel engine
// Issue stage walks channels for ticks, execute stage does RAM read-modify-write.
// ------------------------------------------------------------------
`include "multichannel_servo_pulse_generator_macros.svh"

module mspg_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mspg_pkg::cfg_t cfg_i,
  input  logic           item_valid_i,
  input  mspg_pkg::cmd_t item_i,
  output logic           free_o,
  output logic           res_valid_o,
  output mspg_pkg::res_t res_o
);

  // issue stage
  logic                          a_valid_q, a_tick_q;
  mspg_pkg::opcode_e             a_op_q;
  logic [mspg_pkg::CH_W-1:0]     a_ch_q;
  logic [mspg_pkg::SLOT_W-1:0]   a_amt_q;
  logic [mspg_pkg::CH_IDX_W-1:0] a_cnt_q;
  logic [mspg_pkg::SLOT_W-1:0]   s_q, i_q, slot_q;

  // execute stage
  logic                          b_valid_q, b_tick_q, b_en_q, b_last_q;
  mspg_pkg::opcode_e             b_op_q;
  logic [mspg_pkg::CH_IDX_W-1:0] b_idx_q;
  logic [mspg_pkg::SLOT_W-1:0]   b_d_q, b_amt_q;

  logic                          fwd_v_q;
  logic [mspg_pkg::CH_IDX_W-1:0] fwd_idx_q;
  mspg_pkg::chan_ent_t           fwd_ent_q;
  logic [mspg_pkg::CHANNELS-1:0] vld_q, lvl_q, lvl_d;

  logic                          a_last, a_en, a_ch_ok;
  logic [mspg_pkg::CH_IDX_W-1:0] a_idx;
  logic [mspg_pkg::SLOT_W-1:0]   cyc, slot_cur, slot_nxt, d_calc, s_nxt;
  logic [mspg_pkg::SLOT_W:0]     slot_inc, s_sum;

  logic [mspg_pkg::ENT_W-1:0]    ram_rdata;
  mspg_pkg::chan_ent_t           ent, ent_n;
  logic                          we, lvl;
  logic [mspg_pkg::WORD_W-1:0]   cd_dec;
  logic [mspg_pkg::SLOT_W:0]     w_sum;
  logic [mspg_pkg::SLOT_W-1:0]   w;
  mspg_pkg::status_e             st;

  assign cyc = cfg_i.cyc_eff;

  // ---------------- issue ----------------
  assign a_last = a_tick_q ? (a_cnt_q == mspg_pkg::CH_IDX_W'(mspg_pkg::CHANNELS - 1)) : 1'b1;
  assign free_o = !a_valid_q || a_last;

  assign slot_cur = (slot_q < cyc) ? slot_q : '0;
  assign slot_inc = {1'b0, slot_cur} + (mspg_pkg::SLOT_W + 1)'(1);
  assign slot_nxt = (slot_inc >= {1'b0, cyc}) ? '0 : slot_inc[mspg_pkg::SLOT_W-1:0];

  assign a_ch_ok = (int'(a_ch_q) < mspg_pkg::CHANNELS)
                   && cfg_i.enable[a_ch_q[mspg_pkg::CH_IDX_W-1:0]];
  assign a_idx   = a_tick_q ? a_cnt_q : a_ch_q[mspg_pkg::CH_IDX_W-1:0];
  assign a_en    = a_tick_q ? cfg_i.enable[a_cnt_q] : a_ch_ok;

  // distance from this channel's start slot, mod cycle
  assign d_calc = (i_q >= s_q) ? (i_q - s_q)
                : mspg_pkg::SLOT_W'({1'b0, i_q} + {1'b0, cyc} - {1'b0, s_q});

  // next enabled channel starts one spacing later
  assign s_sum = {1'b0, s_q} + {1'b0, cfg_i.sp_mod};
  assign s_nxt = (s_sum >= {1'b0, cyc}) ? mspg_pkg::SLOT_W'(s_sum - {1'b0, cyc})
                                        : s_sum[mspg_pkg::SLOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_tick_q  <= 1'b0;
      a_op_q    <= mspg_pkg::OP_TICK;
      a_ch_q    <= '0;
      a_amt_q   <= '0;
      a_cnt_q   <= '0;
      s_q       <= '0;
      i_q       <= '0;
      slot_q    <= '0;
    end else begin
      if (item_valid_i) begin
        a_valid_q <= 1'b1;
        a_tick_q  <= (item_i.op == mspg_pkg::OP_TICK);
        a_op_q    <= item_i.op;
        a_ch_q    <= item_i.ch;
        a_amt_q   <= item_i.amt;
        a_cnt_q   <= '0;
        s_q       <= '0;
        if (item_i.op == mspg_pkg::OP_TICK) begin
          i_q    <= slot_cur;
          slot_q <= slot_nxt;
        end
      end else if (a_valid_q) begin
        if (a_last) begin
          a_valid_q <= 1'b0;
        end else begin
          a_cnt_q <= a_cnt_q + mspg_pkg::CH_IDX_W'(1);
        end
        if (a_en) begin
          s_q <= s_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_tick_q  <= 1'b0;
      b_en_q    <= 1'b0;
      b_last_q  <= 1'b0;
      b_op_q    <= mspg_pkg::OP_TICK;
      b_idx_q   <= '0;
      b_d_q     <= '0;
      b_amt_q   <= '0;
    end else begin
      b_valid_q <= a_valid_q;
      b_tick_q  <= a_tick_q;
      b_en_q    <= a_en;
      b_last_q  <= a_last;
      b_op_q    <= a_op_q;
      b_idx_q   <= a_idx;
      b_d_q     <= d_calc;
      b_amt_q   <= a_amt_q;
    end
  end

  // ---------------- channel RAM ----------------
  mspg_ram #(
    .WIDTH (mspg_pkg::ENT_W),
    .DEPTH (mspg_pkg::CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (b_idx_q),
    .wdata_i (ent_n),
    .raddr_i (a_idx),
    .rdata_o (ram_rdata)
  );

  // write in the previous cycle is not yet visible in the read data
  always_comb begin
    if (fwd_v_q && fwd_idx_q == b_idx_q) begin
      ent = fwd_ent_q;
    end else if (vld_q[b_idx_q]) begin
      ent = mspg_pkg::chan_ent_t'(ram_rdata);
    end else begin
      ent = '0;
    end
  end

  // ---------------- execute ----------------
  always_comb begin
    ent_n  = ent;
    lvl    = lvl_q[b_idx_q];
    we     = 1'b0;
    st     = mspg_pkg::ST_OK;
    cd_dec = ent.idle_cnt - mspg_pkg::WORD_W'(1);
    w_sum  = {1'b0, ent.req_width} + {1'b0, b_amt_q};
    case (b_op_q)
      mspg_pkg::OP_INC: begin
        w = (w_sum > {1'b0, cfg_i.max_w}) ? cfg_i.max_w : w_sum[mspg_pkg::SLOT_W-1:0];
      end
      mspg_pkg::OP_DEC: begin
        if (ent.req_width >= b_amt_q && (ent.req_width - b_amt_q) >= cfg_i.min_w) begin
          w = ent.req_width - b_amt_q;
        end else begin
          w = cfg_i.min_w;
        end
      end
      default: w = b_amt_q;
    endcase

    if (b_tick_q) begin
      if (b_en_q) begin
        if (ent.idle_cnt != '0) begin
          ent_n.idle_cnt = cd_dec;
          if (cd_dec == '0) begin
            ent_n.turn_on = 1'b0;
            // full-cycle pulse would never fall on its own
            if (ent.req_width == cyc) begin
              lvl = 1'b0;
            end
          end
        end
        if (b_d_q == '0) begin
          ent_n.act_width = ent.req_width;
          lvl = ent_n.turn_on && (ent.req_width != '0);
        end else if (b_d_q >= ent.act_width) begin
          lvl = 1'b0;
        end
        we = b_valid_q;
      end else begin
        lvl = 1'b0;
      end
    end else begin
      if (!b_en_q) begin
        st = mspg_pkg::ST_DISABLED;
      end else if (w != '0 && (w < cfg_i.min_w || w > cfg_i.max_w)) begin
        st = mspg_pkg::ST_RANGE;
      end else begin
        ent_n.req_width = w;
        ent_n.turn_on   = (w != '0);
        ent_n.idle_cnt  = cfg_i.idle_ticks;
        we              = b_valid_q;
      end
    end

    lvl_d = lvl_q;
    if (b_valid_q && b_tick_q) begin
      lvl_d[b_idx_q] = lvl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q   <= '0;
      vld_q   <= '0;
      fwd_v_q <= 1'b0;
    end else begin
      lvl_q   <= lvl_d;
      fwd_v_q <= we;
      if (we) begin
        vld_q[b_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_idx_q <= b_idx_q;
    fwd_ent_q <= ent_n;
  end

  assign res_valid_o = b_valid_q && b_last_q;

  always_comb begin
    if (b_tick_q) begin
      res_o.kind   = mspg_pkg::KIND_LEVELS;
      res_o.pins   = mspg_pkg::PIN_W'((cfg_i.invert ? ~lvl_d : lvl_d) & cfg_i.enable);
      res_o.status = mspg_pkg::ST_OK;
    end else begin
      res_o.kind   = mspg_pkg::KIND_STATUS;
      res_o.pins   = '0;
      res_o.status = st;
    end
  end

  `MSPG_ASSERT(accept_when_free_a, item_valid_i |-> free_o, "item taken while issue stage busy")
  `MSPG_ASSERT(sweep_steps_a, a_valid_q && a_tick_q && !a_last |=> a_valid_q && a_tick_q && a_cnt_q == $past(a_cnt_q) + mspg_pkg::CH_IDX_W'(1), "channel sweep broken")

endmodule

FILE: sv/mspg_outq.sv
// ------------------------------------------------------------------
// Servo pulse generator result queue
// Small result FIFO with an outstanding-item credit count.
// ------------------------------------------------------------------
`include "multichannel_servo_pulse_generator_macros.svh"

module mspg_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           push_i,
  input  mspg_pkg::res_t push_res_i,
  output logic           space_o,
  mspg_res_if.source     res_o
);

  mspg_pkg::res_t                  q_q [mspg_pkg::OUTQ_DEPTH];
  logic [mspg_pkg::OUTQ_PTR_W-1:0] wptr_q, rptr_q;
  logic [mspg_pkg::OUTQ_CNT_W-1:0] cnt_q, outst_q;
  logic                            pop;

  assign pop     = res_o.valid && res_o.ready;
  // every accepted item owns a queue slot until its result leaves
  assign space_o = (outst_q != mspg_pkg::OUTQ_CNT_W'(mspg_pkg::OUTQ_DEPTH));

  assign res_o.valid       = (cnt_q != '0);
  assign res_o.result_kind = q_q[rptr_q].kind;
  assign res_o.pin_levels  = q_q[rptr_q].pins;
  assign res_o.status      = q_q[rptr_q].status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      cnt_q   <= '0;
      outst_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + mspg_pkg::OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + mspg_pkg::OUTQ_PTR_W'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + mspg_pkg::OUTQ_CNT_W'(1);
      end else if (!push_i && pop) begin
        cnt_q <= cnt_q - mspg_pkg::OUTQ_CNT_W'(1);
      end
      if (accept_i && !pop) begin
        outst_q <= outst_q + mspg_pkg::OUTQ_CNT_W'(1);
      end else if (!accept_i && pop) begin
        outst_q <= outst_q - mspg_pkg::OUTQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_q[wptr_q] <= push_res_i;
    end
  end

  `MSPG_ASSERT(queue_within_credit_a, cnt_q <= outst_q, "queued results exceed outstanding items")
  `MSPG_ASSERT_NEVER(push_into_full_a, push_i && cnt_q == mspg_pkg::OUTQ_CNT_W'(mspg_pkg::OUTQ_DEPTH), "result pushed into full queue")

endmodule

FILE: sv/multichannel_servo_pulse_generator.sv
// ------------------------------------------------------------------
// Multichannel servo pulse generator
// Up to 32 staggered servo pulse channels advanced by tick items and
// retuned by width commands. Per-channel state sits in one RAM that is
// swept one channel per clock: a tick occupies the issue stage for a
// sweep over all CHANNELS channels, then its pin levels pass the execute
// stage and the result queue; a width command needs no sweep, so commands
// may follow each other every cycle while the result queue has room and
// no remainder computation runs. A four-deep result queue lets items keep
// flowing while results wait. A write to cycle_slots or start_spacing
// starts a bit-serial remainder computation during which no items are
// taken; configuration writes are always taken and belong to idle periods.
// ------------------------------------------------------------------
module multichannel_servo_pulse_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  mspg_cmd_if.sink   cmd_i,
  mspg_res_if.source res_o,
  mspg_cfg_if.sink   cfg_i
);

  mspg_pkg::cfg_t cfg;
  mspg_pkg::cmd_t item;
  mspg_pkg::res_t eng_res;
  logic           eng_free, q_space, accept, eng_res_valid;

  assign cmd_i.ready = eng_free && !cfg.busy && q_space;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    item.op  = mspg_pkg::opcode_e'(cmd_i.opcode);
    item.ch  = cmd_i.channel;
    item.amt = cmd_i.amount;
  end

  mspg_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mspg_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (accept),
    .item_i       (item),
    .free_o       (eng_free),
    .res_valid_o  (eng_res_valid),
    .res_o        (eng_res)
  );

  mspg_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .push_i     (eng_res_valid),
    .push_res_i (eng_res),
    .space_o    (q_space),
    .res_o      (res_o)
  );

endmodule

FILE: tb/mspg_scoreboard.sv
// ------------------------------------------------------------------
// Servo pulse generator scoreboard
// Watches the command, result and configuration channels, keeps its
// own copy of the pulse state and compares every result in order.
// ------------------------------------------------------------------
module mspg_scoreboard import mspg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mspg_cmd_if         cmd_i,
  mspg_res_if         res_i,
  mspg_cfg_if         cfg_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  bit [SLOT_W-1:0] cyc_slots, min_w, max_w, spacing;
  bit [WORD_W-1:0] enable_mask, idle_reload;
  bit              invert;

  // pulse state
  bit [SLOT_W-1:0] slot_pos;
  bit [SLOT_W-1:0] req_w [CHANNELS];
  bit [SLOT_W-1:0] act_w [CHANNELS];
  bit              turn_on [CHANNELS];
  bit [WORD_W-1:0] idle_cnt [CHANNELS];
  bit [PIN_W-1:0]  level_bits;

  res_t outcome_q[$];

  function automatic void write_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
    case (cfg_reg_e'(idx))
      REG_CYCLE_SLOTS:    cyc_slots   = value[SLOT_W-1:0];
      REG_MIN_WIDTH:      min_w       = value[SLOT_W-1:0];
      REG_MAX_WIDTH:      max_w       = value[SLOT_W-1:0];
      REG_CHAN_ENABLE:    enable_mask = value;
      REG_START_SPACING:  spacing     = value[SLOT_W-1:0];
      REG_IDLE_TICKS:     idle_reload = value;
      REG_INVERT_OUTPUTS: invert      = value[0];
      default: ;
    endcase
  endfunction

  // one slot step of the pulse cycle; returns the reported pin levels
  function automatic bit [PIN_W-1:0] advance_slot();
    int unsigned cyc, pos, rank, start, offs;
    cyc  = (cyc_slots != 0) ? cyc_slots : 1;
    pos  = (slot_pos < cyc) ? slot_pos : 0;
    rank = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (!enable_mask[c]) begin
        level_bits[c] = 1'b0;
        continue;
      end
      if (idle_cnt[c] != 0) begin
        idle_cnt[c]--;
        if (idle_cnt[c] == 0) begin
          turn_on[c] = 1'b0;
          // a full-cycle pulse never reaches its end slot, so drop it here
          if (req_w[c] == cyc) level_bits[c] = 1'b0;
        end
      end
      start = 32'((64'(rank) * spacing) % cyc);
      rank++;
      offs = (pos >= start) ? pos - start : pos + cyc - start;
      if (offs == 0) begin
        act_w[c]      = req_w[c];
        level_bits[c] = turn_on[c] && (act_w[c] != 0);
      end else if (offs >= act_w[c]) begin
        level_bits[c] = 1'b0;
      end
    end
    slot_pos = SLOT_W'((pos + 1 >= cyc) ? 0 : pos + 1);
    return (invert ? ~level_bits : level_bits) & enable_mask;
  endfunction

  function automatic status_e apply_width_cmd(opcode_e op, bit [CH_W-1:0] ch,
                                              bit [SLOT_W-1:0] amt);
    int unsigned cur, w;
    if (!enable_mask[ch]) return ST_DISABLED;
    cur = req_w[ch];
    case (op)
      OP_SET: w = amt;
      OP_INC: begin
        w = cur + amt;
        if (w > max_w) w = max_w;
      end
      default: w = (cur >= amt && cur - amt >= min_w) ? cur - amt : min_w;
    endcase
    if (w != 0 && (w < min_w || w > max_w)) return ST_RANGE;
    req_w[ch]    = SLOT_W'(w);
    turn_on[ch]  = (w != 0);
    idle_cnt[ch] = idle_reload;
    return ST_OK;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t    want;
    opcode_e op;
    if (!rst_ni) begin
      cyc_slots   = RST_CYCLE_SLOTS;
      min_w       = RST_MIN_WIDTH;
      max_w       = RST_MAX_WIDTH;
      enable_mask = RST_CHAN_ENABLE;
      spacing     = RST_START_SPACING;
      idle_reload = RST_IDLE_TICKS;
      invert      = 1'b0;
      slot_pos    = '0;
      level_bits  = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        req_w[c]    = '0;
        act_w[c]    = '0;
        turn_on[c]  = 1'b0;
        idle_cnt[c] = '0;
      end
      outcome_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) write_register(cfg_i.index, cfg_i.data);

      if (cmd_i.valid && cmd_i.ready) begin
        op = opcode_e'(cmd_i.opcode);
        if (op == OP_TICK) begin
          want.kind   = KIND_LEVELS;
          want.pins   = advance_slot();
          want.status = ST_OK;
        end else begin
          want.kind   = KIND_STATUS;
          want.pins   = '0;
          want.status = apply_width_cmd(op, cmd_i.channel, cmd_i.amount);
        end
        outcome_q.push_back(want);
      end

      if (res_i.valid && res_i.ready) begin
        if (outcome_q.size() == 0) begin
          $error("unexpected item: result_kind %0d pin_levels %h status %0d",
                 res_i.result_kind, res_i.pin_levels, res_i.status);
          fail_cnt_o++;
        end else begin
          want = outcome_q.pop_front();
          if (res_i.result_kind !== want.kind) begin
            $error("result_kind: expected %0d, actual %0d", want.kind, res_i.result_kind);
            fail_cnt_o++;
          end
          if (res_i.pin_levels !== want.pins) begin
            $error("pin_levels: expected %h, actual %h", want.pins, res_i.pin_levels);
            fail_cnt_o++;
          end
          if (res_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_i.status);
            fail_cnt_o++;
          end
        end
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

FILE: tb/tb_multichannel_servo_pulse_generator.sv
// ------------------------------------------------------------------
// Servo pulse generator testbench
// Directed width commands and ticks at the reset setup, then phases of random
// ticks and width commands under fixed extreme and random register
// setups, with random gaps on the command side and random stalls on
// the result side. The scoreboard predicts and checks every result.
// ------------------------------------------------------------------
module tb_multichannel_servo_pulse_generator import mspg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 120;
  localparam int SETTLE_CYC  = 40;

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet = 1'b0;

  int unsigned fail_cnt, pending;
  int unsigned hold_left;

  // current register setup, mirrored here only to shape the stimulus
  int unsigned cur_cyc, cur_min, cur_max, cur_space, cur_idle;
  bit [WORD_W-1:0] cur_en;
  bit              cur_inv;

  mspg_cmd_if cmd_ch ();
  mspg_res_if res_ch ();
  mspg_cfg_if cfg_ch ();

  multichannel_servo_pulse_generator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  mspg_scoreboard u_scoreboard (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cmd_i      (cmd_ch),
    .res_i      (res_ch),
    .cfg_i      (cfg_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall bursts, none once quiet
  initial begin
    res_ch.ready = 1'b0;
    hold_left    = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
      end else if (res_ch.ready && !quiet && $urandom_range(0, 3) == 0) begin
        res_ch.ready = 1'b0;
        hold_left    = $urandom_range(0, 4);
      end else begin
        res_ch.ready = 1'b1;
        hold_left    = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(0, 15);
      end
    end
  end

  task automatic push_item(opcode_e op, bit [CH_W-1:0] ch, bit [SLOT_W-1:0] amt);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    cmd_ch.valid   = 1'b1;
    cmd_ch.opcode  = op;
    cmd_ch.channel = ch;
    cmd_ch.amount  = amt;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, bit [WORD_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic settle();
    cmd_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // narrow registers get random upper bits, which the block drops
  task automatic apply_config();
    bit [WORD_W-1:0] v;
    v = $urandom; v[SLOT_W-1:0] = SLOT_W'(cur_cyc);   write_reg(REG_CYCLE_SLOTS, v);
    v = $urandom; v[SLOT_W-1:0] = SLOT_W'(cur_min);   write_reg(REG_MIN_WIDTH, v);
    v = $urandom; v[SLOT_W-1:0] = SLOT_W'(cur_max);   write_reg(REG_MAX_WIDTH, v);
    write_reg(REG_CHAN_ENABLE, cur_en);
    v = $urandom; v[SLOT_W-1:0] = SLOT_W'(cur_space); write_reg(REG_START_SPACING, v);
    write_reg(REG_IDLE_TICKS, cur_idle);
    v = $urandom; v[0] = cur_inv;                     write_reg(REG_INVERT_OUTPUTS, v);
  endtask

  task automatic run_items(int unsigned n);
    opcode_e         op;
    bit [CH_W-1:0]   ch;
    bit [SLOT_W-1:0] amt;
    int unsigned     r;
    repeat (n) begin
      ch  = CH_W'($urandom);
      amt = SLOT_W'($urandom);
      if ($urandom_range(0, 99) < 55) begin
        op = OP_TICK;
      end else begin
        op = opcode_e'($urandom_range(1, 3));
        if (cur_en != 0 && $urandom_range(0, 9) < 8) begin
          while (!cur_en[ch]) ch = CH_W'($urandom);
        end
        r = $urandom_range(0, 9);
        if (r == 0) amt = '0;
        else if (r >= 3) begin
          if (op == OP_SET) amt = SLOT_W'($urandom_range(0, cur_max + 2));
          else amt = SLOT_W'($urandom_range(0, cur_max / 2 + 3));
        end
      end
      push_item(op, ch, amt);
    end
  endtask

  initial begin
    int unsigned n_items;
    cmd_ch.valid   = 1'b0;
    cmd_ch.opcode  = OP_TICK;
    cmd_ch.channel = '0;
    cmd_ch.amount  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_CYCLE_SLOTS;
    cfg_ch.data    = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset setup: widths 50..250, channels 0..7 in use
    push_item(OP_SET, 5'd0, 19'd250);
    push_item(OP_SET, 5'd1, 19'd50);
    push_item(OP_SET, 5'd2, 19'd49);
    push_item(OP_SET, 5'd3, 19'd251);
    push_item(OP_SET, 5'd4, 19'd0);
    push_item(OP_SET, 5'd8, 19'd100);
    push_item(OP_SET, 5'd31, 19'h7FFFF);
    push_item(OP_SET, 5'd5, 19'h7FFFF);
    push_item(OP_INC, 5'd1, 19'h7FFFF);
    push_item(OP_INC, 5'd0, 19'd0);
    push_item(OP_DEC, 5'd1, 19'd1000);
    push_item(OP_DEC, 5'd0, 19'd10);
    push_item(OP_DEC, 5'd4, 19'd5);
    push_item(OP_INC, 5'd6, 19'd10);
    push_item(OP_TICK, 5'd31, 19'h7FFFF);
    push_item(OP_TICK, 5'd0, 19'd0);
    push_item(OP_SET, 5'd7, 19'd120);
    push_item(OP_DEC, 5'd7, 19'h7FFFF);
    push_item(OP_TICK, 5'd0, 19'd0);
    push_item(OP_SET, 5'd3, 19'd0);
    push_item(OP_TICK, 5'd0, 19'd0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      n_items = PHASE_ITEMS;
      case (p)
        0: begin  // full width equal to the cycle, all channels
          cur_cyc = 20; cur_min = 1; cur_max = 20; cur_en = '1;
          cur_space = 3; cur_idle = 40; cur_inv = 1'b0;
        end
        1: begin  // zero cycle length behaves as one slot
          cur_cyc = 0; cur_min = 0; cur_max = 1; cur_en = $urandom;
          cur_space = 0; cur_idle = 5; cur_inv = 1'b1;
        end
        2: begin  // nothing in use, limits crossed
          cur_cyc = 7; cur_min = 5; cur_max = 3; cur_en = '0;
          cur_space = 19'h7FFFF; cur_idle = 32'hFFFF_FFFF; cur_inv = 1'b1;
          n_items = PHASE_ITEMS / 2;
        end
        3: begin  // longest cycle, widest widths
          cur_cyc = 19'h7FFFF; cur_min = 0; cur_max = 19'h7FFFF;
          cur_en = 32'h8000_0001; cur_space = 19'h7FFFE; cur_idle = 1;
          cur_inv = 1'b0;
        end
        default: begin
          case ($urandom_range(0, 9))
            7, 8:    cur_cyc = $urandom_range(100, 300);
            9:       cur_cyc = $urandom_range(0, 2);
            default: cur_cyc = $urandom_range(1, 40);
          endcase
          if ($urandom_range(0, 9) == 0) begin
            cur_min = $urandom_range(0, cur_cyc + 2);
            cur_max = $urandom_range(1, cur_min + 1);
          end else begin
            cur_min = $urandom_range(0, cur_cyc / 3);
            cur_max = $urandom_range((cur_min != 0) ? cur_min : 1, cur_cyc + 3);
          end
          case ($urandom_range(0, 3))
            0:       cur_en = $urandom;
            1:       cur_en = $urandom & $urandom;
            2:       cur_en = $urandom | $urandom;
            default: cur_en = 32'h1 << $urandom_range(0, 31);
          endcase
          cur_space = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 19'h7FFFF)
                                                  : $urandom_range(0, cur_cyc + 2);
          cur_idle  = $urandom_range(0, 1) ? $urandom_range(1, 60) : 0;
          cur_inv   = 1'($urandom_range(0, 1));
        end
      endcase
      apply_config();
      if (p == PHASES - 1) quiet = 1'b1;
      run_items(n_items);
    end

    cmd_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/mspg_pkg.sv
sv/mspg_ifs.sv
sv/mspg_ram.sv
sv/mspg_cfg.sv
sv/mspg_engine.sv
sv/mspg_outq.sv
sv/multichannel_servo_pulse_generator.sv
tb/mspg_scoreboard.sv
tb/tb_multichannel_servo_pulse_generator.sv
